// ===== rtl/pcmid_pkg.sv =====
package pcmid_pkg;

	localparam int IN_W   = 24;
	localparam int USER_W = 2;
	localparam int OUT_W  = 32;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 13;
	localparam int POS_W  = 26;

	typedef logic [USER_W-1:0] op_t;

	localparam op_t OP_START = 2'd0;
	localparam op_t OP_BIT   = 2'd1;
	localparam op_t OP_READ  = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_EIGHT  = 2'd2;

endpackage

// ===== rtl/pcmid_ram.sv =====
module pcmid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/position_copy_mtf_image_decoder.sv =====
// Bit-serial picture decoder with position copies and move-to-front literals.
// Input items arrive on s_*: s_tuser carries the operation (start, stream
// bit, read pixel), s_tdata the stream bit and the read address. Every item
// gives exactly one result item on m_*, holding the pixel read (zero for
// other operations), the count of decoded pixels and a finished flag.
// Registers are written through cfg_*, which is always ready; write them only
// while no item is in flight.
// A start, a plain stream bit or an unused operation goes straight to the
// result; a read first fetches the pixel from memory. A bit that completes a
// literal reads the previous pixel from memory when its row depends on it,
// fills the recency row in the table memory the first time that row is used
// after a start, then moves the colour at its rank to the front. A completed
// length code reads the two pixels before when the distance depends on them,
// then copies each pixel with one read and one write of the pixel memory. The
// next item is taken as soon as the result is placed in the output register,
// so a stalled receiver holds one finished result while the next item is
// decoded; a second result waits for the register.
// After reset the decoder is in the state of a fresh start item with the
// default registers; no memory clearing pass is needed, as recency rows carry
// valid bits and the decoder reads pixel memory only where it has written it.
module position_copy_mtf_image_decoder #(
	parameter int MAX_PIXELS      = 262144,
	parameter int MAX_LENGTH_BITS = 23
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// stream_bit [0], read_address [18:1], zero [23:19]
	input  logic [pcmid_pkg::IN_W-1:0]   s_tdata,
	// op [1:0]
	input  logic [pcmid_pkg::USER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pixel_index [7:0], pixels_done [26:8], finished [27], zero [31:28]
	output logic [pcmid_pkg::OUT_W-1:0]  m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pcmid_pkg::CFG_IW-1:0] cfg_index,
	input  logic [pcmid_pkg::CFG_DW-1:0] cfg_data
);

	import pcmid_pkg::*;

	localparam int AW  = $clog2(MAX_PIXELS);
	localparam int CVW = MAX_LENGTH_BITS + 1;
	localparam int CBW = $clog2(MAX_LENGTH_BITS + 1);
	localparam logic [POS_W:0] MAXP = (POS_W + 1)'(MAX_PIXELS);
	localparam logic [POS_W:0] DONE_CAP = (POS_W + 1)'(20'h7ffff);

	localparam logic [3:0] PH_LIT_HEAD  = 4'd0;
	localparam logic [3:0] PH_LIT_SHORT = 4'd1;
	localparam logic [3:0] PH_LIT_UNARY = 4'd2;
	localparam logic [3:0] PH_LIT_LOW   = 4'd3;
	localparam logic [3:0] PH_POS_A     = 4'd4;
	localparam logic [3:0] PH_POS_B     = 4'd5;
	localparam logic [3:0] PH_POS_C     = 4'd6;
	localparam logic [3:0] PH_LEN_UNARY = 4'd7;
	localparam logic [3:0] PH_LEN_LOW   = 4'd8;
	localparam logic [3:0] PH_CONT      = 4'd9;
	localparam logic [3:0] PH_DONE      = 4'd10;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EMIT  = 4'd1;
	localparam logic [3:0] ST_RDPIX = 4'd2;
	localparam logic [3:0] ST_LPREV = 4'd3;
	localparam logic [3:0] ST_LROW  = 4'd4;
	localparam logic [3:0] ST_FILL  = 4'd5;
	localparam logic [3:0] ST_MCOL  = 4'd6;
	localparam logic [3:0] ST_MSH   = 4'd7;
	localparam logic [3:0] ST_MHEAD = 4'd8;
	localparam logic [3:0] ST_RUN0  = 4'd9;
	localparam logic [3:0] ST_RUNA  = 4'd10;
	localparam logic [3:0] ST_RUNB  = 4'd11;
	localparam logic [3:0] ST_RUNRD = 4'd12;
	localparam logic [3:0] ST_RUNWR = 4'd13;

	localparam logic [2:0] NO_POS = 3'd7;

	logic [12:0] w_q, h_q;
	logic        e8_q;
	logic [3:0]  st_q, st_d;
	logic [3:0]  phase_q, phase_d;
	logic [CBW-1:0] cb_q, cb_d;
	logic [CVW-1:0] cv_q, cv_d, cvn;
	logic [POS_W-1:0] wp_q, wp_d;
	logic [2:0]  ppos_q, ppos_d;
	logic [1:0]  slot_q, slot_d;
	logic [7:0]  seed0_q, seed0_d, seed1_q, seed1_d;
	logic [7:0]  mask_q, mask_d;
	logic [255:0] rv_q, rv_d;
	logic [7:0]  rank_q, rank_d, row_q, row_d, col_q, col_d, colour_q, colour_d;
	logic [CVW-1:0] len_q, len_d;
	logic [31:0] dist_q, dist_d;
	logic [POS_W-1:0] end_q, end_d;
	logic [7:0]  pix_q, pix_d, a_q, a_d;
	logic        seedsrc_q, seedsrc_d;
	logic        prok_q;
	logic        mv_q;
	logic [OUT_W-1:0] md_q;

	logic [POS_W-1:0] count;
	logic [CBW-1:0]   litmax;
	logic             acc, load;
	op_t              in_op;
	logic             in_bit;
	logic [17:0]      in_addr;
	logic [POS_W:0]   wp1;
	logic [CVW:0]     len2;
	logic [2:0]       tp;
	logic             tp_go;
	logic             lit_go, run_go;
	logic [7:0]       lit_rank;
	logic [CVW-1:0]   run_len;
	logic [POS_W:0]   done_v;

	logic             pr_req, pw_req, pr_en, pw_en;
	logic [POS_W-1:0] pr_pos, pw_pos;
	logic [7:0]       pw_val, prdata, pdata;
	logic             rr_en, rw_en;
	logic [15:0]      rr_addr, rw_addr;
	logic [7:0]       rw_data, rrdata;

	assign count    = {13'd0, w_q} * {13'd0, h_q};
	assign litmax   = e8_q ? CBW'(7) : CBW'(3);
	assign s_tready = (st_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_op    = s_tuser;
	assign in_bit   = s_tdata[0];
	assign in_addr  = s_tdata[18:1];
	assign cfg_ready = 1'b1;
	assign wp1      = {1'b0, wp_q} + (POS_W + 1)'(1);
	assign cvn      = {cv_q[CVW-2:0], in_bit};
	assign len2     = {len_q, 1'b0};
	assign pdata    = prok_q ? prdata : 8'd0;
	assign load     = (st_q == ST_EMIT) && (!mv_q || m_tready);
	assign done_v   = ({1'b0, wp_q} >= MAXP) ? MAXP : {1'b0, wp_q};

	assign pr_en = pr_req && ({1'b0, pr_pos} < MAXP);
	assign pw_en = pw_req && ({1'b0, pw_pos} < MAXP);

	always_comb begin
		st_d      = st_q;
		phase_d   = phase_q;
		cb_d      = cb_q;
		cv_d      = cv_q;
		wp_d      = wp_q;
		ppos_d    = ppos_q;
		slot_d    = slot_q;
		seed0_d   = seed0_q;
		seed1_d   = seed1_q;
		mask_d    = mask_q;
		rv_d      = rv_q;
		rank_d    = rank_q;
		row_d     = row_q;
		col_d     = col_q;
		colour_d  = colour_q;
		len_d     = len_q;
		dist_d    = dist_q;
		end_d     = end_q;
		pix_d     = pix_q;
		a_d       = a_q;
		seedsrc_d = seedsrc_q;
		pr_req    = 1'b0;
		pr_pos    = wp_q;
		pw_req    = 1'b0;
		pw_pos    = wp_q;
		pw_val    = 8'd0;
		rr_en     = 1'b0;
		rr_addr   = {row_q, rank_q};
		rw_en     = 1'b0;
		rw_addr   = {row_q, col_q};
		rw_data   = 8'd0;
		tp        = 3'd0;
		tp_go     = 1'b0;
		lit_go    = 1'b0;
		lit_rank  = 8'd0;
		run_go    = 1'b0;
		run_len   = CVW'(1);

		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					pix_d = 8'd0;
					st_d  = ST_EMIT;
					case (in_op)
						OP_START: begin
							rv_d    = '0;
							mask_d  = e8_q ? 8'hff : 8'h0f;
							seed0_d = 8'd0;
							seed1_d = 8'd0;
							phase_d = PH_LIT_HEAD;
							slot_d  = 2'd0;
							cb_d    = '0;
							cv_d    = '0;
							wp_d    = '0;
							ppos_d  = NO_POS;
						end
						OP_READ: begin
							pr_req = 1'b1;
							pr_pos = POS_W'(in_addr);
							st_d   = ST_RDPIX;
						end
						OP_BIT: begin
							unique case (phase_q)
								PH_LIT_HEAD: begin
									if (in_bit) begin
										phase_d = PH_LIT_SHORT;
									end else begin
										cb_d    = CBW'(1);
										cv_d    = CVW'(1);
										phase_d = (CBW'(1) >= litmax) ? PH_LIT_LOW : PH_LIT_UNARY;
									end
								end
								PH_LIT_SHORT: begin
									lit_go   = 1'b1;
									lit_rank = {7'd0, in_bit};
								end
								PH_LIT_UNARY: begin
									if (in_bit) begin
										cb_d = cb_q + CBW'(1);
										if (cb_q + CBW'(1) >= litmax) begin
											phase_d = PH_LIT_LOW;
										end
									end else begin
										phase_d = PH_LIT_LOW;
									end
								end
								PH_LIT_LOW: begin
									cv_d = cvn;
									if (cvn >= (CVW'(1) << cb_q)) begin
										lit_go   = 1'b1;
										lit_rank = cvn[7:0];
									end
								end
								PH_POS_A: begin
									if (wp_q >= count) begin
										phase_d = PH_DONE;
									end else begin
										cv_d    = CVW'(in_bit);
										phase_d = PH_POS_B;
									end
								end
								PH_POS_B: begin
									cv_d = cvn;
									if ({cv_q[0], in_bit} == 2'd3) begin
										phase_d = PH_POS_C;
									end else begin
										tp_go = 1'b1;
										tp    = {1'b0, cv_q[0], in_bit};
									end
								end
								PH_POS_C: begin
									tp_go = 1'b1;
									tp    = in_bit ? 3'd4 : 3'd3;
								end
								PH_LEN_UNARY: begin
									if (in_bit) begin
										cb_d = cb_q + CBW'(1);
										if (int'(cb_q) + 1 >= MAX_LENGTH_BITS) begin
											cv_d    = CVW'(1);
											phase_d = PH_LEN_LOW;
										end
									end else if (cb_q == '0) begin
										run_go  = 1'b1;
										run_len = CVW'(1);
									end else begin
										cv_d    = CVW'(1);
										phase_d = PH_LEN_LOW;
									end
								end
								PH_LEN_LOW: begin
									cv_d = cvn;
									if (cvn >= (CVW'(1) << cb_q)) begin
										run_go  = 1'b1;
										run_len = cvn;
									end
								end
								PH_CONT: begin
									if (wp_q >= count) begin
										phase_d = PH_DONE;
									end else if (in_bit) begin
										slot_d  = 2'd2;
										phase_d = PH_LIT_HEAD;
										cb_d    = '0;
										cv_d    = '0;
									end else begin
										cb_d    = '0;
										cv_d    = '0;
										phase_d = PH_POS_A;
									end
								end
								default: begin
								end
							endcase
						end
						default: begin
						end
					endcase
				end
				if (tp_go) begin
					cb_d = '0;
					cv_d = '0;
					if (tp == ppos_q) begin
						slot_d  = 2'd2;
						phase_d = PH_LIT_HEAD;
					end else begin
						ppos_d  = tp;
						phase_d = PH_LEN_UNARY;
					end
				end
				if (lit_go) begin
					rank_d = lit_rank;
					if (slot_q == 2'd0) begin
						row_d = 8'd0;
						st_d  = ST_LROW;
					end else if (slot_q == 2'd1) begin
						row_d = seed0_q;
						st_d  = ST_LROW;
					end else if (wp_q == '0) begin
						row_d = 8'd0;
						st_d  = ST_LROW;
					end else begin
						pr_req = 1'b1;
						pr_pos = wp_q - POS_W'(1);
						st_d   = ST_LPREV;
					end
				end
				if (run_go) begin
					len_d = run_len;
					st_d  = ST_RUN0;
				end
			end
			ST_RDPIX: begin
				pix_d = pdata;
				st_d  = ST_EMIT;
			end
			ST_LPREV: begin
				row_d = pdata;
				st_d  = ST_LROW;
			end
			ST_LROW: begin
				if (!rv_q[row_q]) begin
					col_d = 8'd0;
					st_d  = ST_FILL;
				end else begin
					rr_en   = 1'b1;
					rr_addr = {row_q, rank_q};
					st_d    = ST_MCOL;
				end
			end
			ST_FILL: begin
				rw_en   = 1'b1;
				rw_data = (row_q - col_q) & mask_q;
				col_d   = col_q + 8'd1;
				if (col_q == 8'hff) begin
					rv_d[row_q] = 1'b1;
					st_d        = ST_LROW;
				end
			end
			ST_MCOL: begin
				colour_d = rrdata;
				col_d    = rank_q;
				if (rank_q == 8'd0) begin
					st_d = ST_MHEAD;
				end else begin
					rr_en   = 1'b1;
					rr_addr = {row_q, rank_q - 8'd1};
					st_d    = ST_MSH;
				end
			end
			ST_MSH: begin
				rw_en   = 1'b1;
				rw_data = rrdata;
				col_d   = col_q - 8'd1;
				if (col_q == 8'd1) begin
					st_d = ST_MHEAD;
				end else begin
					rr_en   = 1'b1;
					rr_addr = {row_q, col_q - 8'd2};
				end
			end
			ST_MHEAD: begin
				rw_en   = 1'b1;
				rw_addr = {row_q, 8'd0};
				rw_data = colour_q;
				cb_d    = '0;
				cv_d    = '0;
				st_d    = ST_EMIT;
				if (slot_q == 2'd0) begin
					seed0_d = colour_q;
					if (count > POS_W'(1)) begin
						slot_d  = 2'd1;
						phase_d = PH_LIT_HEAD;
					end else begin
						phase_d = (wp_q < count) ? PH_POS_A : PH_DONE;
					end
				end else if (slot_q == 2'd1) begin
					seed1_d = colour_q;
					phase_d = (wp_q < count) ? PH_POS_A : PH_DONE;
				end else begin
					pw_req = 1'b1;
					pw_pos = wp_q;
					pw_val = colour_q;
					wp_d   = wp1[POS_W-1:0];
					if (slot_q == 2'd2 && wp1 < {1'b0, count}) begin
						slot_d  = 2'd3;
						phase_d = PH_LIT_HEAD;
					end else begin
						ppos_d  = NO_POS;
						phase_d = (wp1 < {1'b0, count}) ? PH_CONT : PH_DONE;
					end
				end
			end
			ST_RUN0: begin
				if (count <= wp_q) begin
					end_d = wp_q;
				end else if ((POS_W + 2)'(len2) > (POS_W + 2)'(count - wp_q)) begin
					end_d = count;
				end else begin
					end_d = wp_q + POS_W'(len2);
				end
				st_d = ST_RUNRD;
				case (ppos_q)
					3'd0: begin
						if (wp_q < POS_W'(2)) begin
							dist_d = (seed0_q == seed1_q) ? 32'd2 : 32'd4;
						end else begin
							pr_req = 1'b1;
							pr_pos = wp_q - POS_W'(2);
							st_d   = ST_RUNA;
						end
					end
					3'd1: dist_d = {19'd0, w_q};
					3'd2: dist_d = {18'd0, w_q, 1'b0};
					3'd3: dist_d = {19'd0, w_q} - 32'd1;
					default: dist_d = {19'd0, w_q} + 32'd1;
				endcase
			end
			ST_RUNA: begin
				a_d    = pdata;
				pr_req = 1'b1;
				pr_pos = wp_q - POS_W'(1);
				st_d   = ST_RUNB;
			end
			ST_RUNB: begin
				dist_d = (a_q == pdata) ? 32'd2 : 32'd4;
				st_d   = ST_RUNRD;
			end
			ST_RUNRD: begin
				if (wp_q < end_q && {1'b0, wp_q} < MAXP) begin
					st_d = ST_RUNWR;
					if ({6'd0, wp_q} >= dist_q) begin
						seedsrc_d = 1'b0;
						pr_req    = 1'b1;
						pr_pos    = wp_q - dist_q[POS_W-1:0];
					end else begin
						seedsrc_d = 1'b1;
					end
				end else begin
					wp_d    = end_q;
					cb_d    = '0;
					cv_d    = '0;
					phase_d = (end_q < count) ? PH_POS_A : PH_DONE;
					st_d    = ST_EMIT;
				end
			end
			ST_RUNWR: begin
				pw_req = 1'b1;
				pw_pos = wp_q;
				if (seedsrc_q) begin
					pw_val = (dist_q[0] ^ wp_q[0]) ? seed1_q : seed0_q;
				end else begin
					pw_val = pdata;
				end
				wp_d = wp_q + POS_W'(1);
				st_d = ST_RUNRD;
			end
			ST_EMIT: begin
				if (load) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= 13'd640;
			h_q     <= 13'd400;
			e8_q    <= 1'b0;
			st_q    <= ST_IDLE;
			phase_q <= PH_LIT_HEAD;
			cb_q    <= '0;
			cv_q    <= '0;
			wp_q    <= '0;
			ppos_q  <= NO_POS;
			slot_q  <= 2'd0;
			seed0_q <= 8'd0;
			seed1_q <= 8'd0;
			mask_q  <= 8'h0f;
			rv_q    <= '0;
			prok_q  <= 1'b0;
			mv_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WIDTH:  w_q  <= cfg_data;
					CFG_HEIGHT: h_q  <= cfg_data;
					CFG_EIGHT:  e8_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			st_q    <= st_d;
			phase_q <= phase_d;
			cb_q    <= cb_d;
			cv_q    <= cv_d;
			wp_q    <= wp_d;
			ppos_q  <= ppos_d;
			slot_q  <= slot_d;
			seed0_q <= seed0_d;
			seed1_q <= seed1_d;
			mask_q  <= mask_d;
			rv_q    <= rv_d;
			prok_q  <= pr_en;
			if (load) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rank_q    <= rank_d;
		row_q     <= row_d;
		col_q     <= col_d;
		colour_q  <= colour_d;
		len_q     <= len_d;
		dist_q    <= dist_d;
		end_q     <= end_d;
		pix_q     <= pix_d;
		a_q       <= a_d;
		seedsrc_q <= seedsrc_d;
		if (load) begin
			md_q <= {4'd0, phase_q == PH_DONE,
			         (done_v > DONE_CAP) ? DONE_CAP[18:0] : done_v[18:0], pix_q};
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;

	pcmid_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PIXELS)
	) u_pixel_ram (
		.clk  (clk),
		.we   (pw_en),
		.waddr(pw_pos[AW-1:0]),
		.wdata(pw_val),
		.re   (pr_en),
		.raddr(pr_pos[AW-1:0]),
		.rdata(prdata)
	);

	pcmid_ram #(
		.WIDTH(8),
		.DEPTH(65536)
	) u_recency_ram (
		.clk  (clk),
		.we   (rw_en),
		.waddr(rw_addr),
		.wdata(rw_data),
		.re   (rr_en),
		.raddr(rr_addr),
		.rdata(rrdata)
	);

endmodule

// ===== rtl/pcmid_checker.sv =====
module pcmid_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [pcmid_pkg::USER_W-1:0] s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pcmid_pkg::OUT_W-1:0]  m_tdata
);

	import pcmid_pkg::*;

	logic [1:0] cnt_q;
	logic       start_q;
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			start_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, s_acc} - {1'b0, m_acc};
			if (m_acc) begin
				start_q <= 1'b0;
			end else if (s_acc && s_tuser == OP_START && cnt_q == 2'd0) begin
				start_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("more than two items in flight");

	a_nophantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 2'd0)
		else $error("result without an item");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && start_q |-> m_tdata[27:0] == 28'd0)
		else $error("start result not cleared");

endmodule

bind position_copy_mtf_image_decoder pcmid_checker u_pcmid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
